>>> sv/icmp_erm_pkg.sv
// Package: shared types, codes and helpers of the ICMP echo reply matcher.
package icmp_erm_pkg;

	localparam int TABLE_DEPTH_DEF = 16;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_FAMILY_IPV6    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OWN_IDENTIFIER = 1'd1;

	localparam logic [1:0] KIND_SEND  = 2'd0;
	localparam logic [1:0] KIND_BYTE  = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;

	localparam logic [2:0] VERDICT_IGNORED    = 3'd0;
	localparam logic [2:0] VERDICT_REPLY      = 3'd1;
	localparam logic [2:0] VERDICT_ERROR      = 3'd2;
	localparam logic [2:0] VERDICT_RECORDED   = 3'd3;
	localparam logic [2:0] VERDICT_TABLE_FULL = 3'd4;
	localparam logic [2:0] VERDICT_CLEARED    = 3'd5;

	localparam logic [7:0] V4_ECHO_REPLY    = 8'd0;
	localparam logic [7:0] V4_ECHO_REQUEST  = 8'd8;
	localparam logic [7:0] V4_TIME_EXCEEDED = 8'd11;
	localparam logic [7:0] V4_UNREACHABLE   = 8'd3;
	localparam logic [7:0] V6_ECHO_REPLY    = 8'd129;
	localparam logic [7:0] V6_ECHO_REQUEST  = 8'd128;
	localparam logic [7:0] V6_TIME_EXCEEDED = 8'd3;
	localparam logic [7:0] V6_UNREACHABLE   = 8'd1;

	localparam logic [7:0] V6_HOP_LIMIT      = 8'd64;
	localparam logic [5:0] V6_INNER_HDR_LEN  = 6'd40;
	localparam logic [15:0] V4_MIN_REPLY_LEN = 16'd28;
	localparam logic [15:0] V6_MIN_REPLY_LEN = 16'd8;
	localparam logic [15:0] MIN_ERROR_LEN    = 16'd56;
	localparam logic [15:0] ICMP_HDR_LEN     = 16'd8;
	localparam logic [15:0] POS_MAX          = 16'hFFFF;
	localparam logic [15:0] TTL_OFFSET       = 16'd8;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] send_sequence;
		logic [7:0]  data_byte;
		logic        last_byte;
	} req_item_t;

	typedef struct packed {
		logic [2:0]  verdict;
		logic [15:0] matched_sequence;
		logic [7:0]  hop_limit;
		logic [15:0] icmp_length;
		logic [7:0]  icmp_kind_seen;
	} rsp_item_t;

	// controller -> datapath
	typedef struct packed {
		logic take;
		logic load_out;
	} ctl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic has_result;
	} dp_sts_t;

	// Header field capture: type at base, identifier at base+4..5, sequence at base+6..7.
	function automatic logic [39:0] capture(input logic [39:0] f, input logic [15:0] p,
			input logic [7:0] base, input logic [7:0] b);
		logic [39:0] r;
		logic [15:0] bs;
		r  = f;
		bs = {8'd0, base};
		if (p == bs)          r[39:32] = b;
		if (p == bs + 16'd4)  r[31:24] = b;
		if (p == bs + 16'd5)  r[23:16] = b;
		if (p == bs + 16'd6)  r[15:8]  = b;
		if (p == bs + 16'd7)  r[7:0]   = b;
		return r;
	endfunction

endpackage

>>> sv/icmp_erm_ctrl.sv
// Controller: transfer handshake and output register occupancy.
module icmp_erm_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	output logic                   req_stall,
	output logic                   rsp_valid,
	input  logic                   rsp_stall,
	input  icmp_erm_pkg::dp_sts_t  sts,
	output icmp_erm_pkg::ctl_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_EMPTY = 2'b01,
		ST_FULL  = 2'b10
	} state_t;

	state_t state_q, state_next;

	always_comb begin
		req_stall    = (state_q == ST_FULL) && rsp_stall;
		rsp_valid    = (state_q == ST_FULL);
		cmd.take     = req_valid && !req_stall;
		cmd.load_out = cmd.take && sts.has_result;
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_EMPTY: begin
				if (cmd.load_out) state_next = ST_FULL;
			end
			ST_FULL: begin
				if (cmd.load_out)    state_next = ST_FULL;
				else if (!rsp_stall) state_next = ST_EMPTY;
			end
			default: state_next = ST_EMPTY;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_EMPTY;
		else         state_q <= state_next;
	end

endmodule

>>> sv/icmp_erm_dp.sv
// Datapath: sequence table, packet parser, verdict and output register.
module icmp_erm_dp #(
	parameter int TABLE_DEPTH = icmp_erm_pkg::TABLE_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [icmp_erm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [icmp_erm_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  icmp_erm_pkg::req_item_t             req,
	output icmp_erm_pkg::rsp_item_t             rsp,
	input  icmp_erm_pkg::ctl_cmd_t              cmd,
	output icmp_erm_pkg::dp_sts_t               sts
);

	logic        v6_q;
	logic [15:0] own_id_q;

	logic [TABLE_DEPTH-1:0] valid_q;
	logic [15:0]            seq_q [TABLE_DEPTH];

	logic [15:0] pos_q;
	logic [5:0]  ohl_q, ihl_q;
	logic [7:0]  ttl_q;
	logic [39:0] of_q, if_q;

	icmp_erm_pkg::rsp_item_t rsp_q, rsp_next;

	logic        is_send, is_byte, is_clear;
	logic [7:0]  b;
	logic [15:0] pos_next;
	logic [5:0]  ohl_eff, h, ihl_eff;
	logic [7:0]  ttl_eff;
	logic [6:0]  ib;
	logic [7:0]  ibase;
	logic [39:0] of_new, if_new;
	logic [15:0] count;
	logic        outer_ok, inner_ok, is_err, is_rep, try_match;
	logic [15:0] cand_seq, key;
	logic [TABLE_DEPTH-1:0] hit, free_oh;
	logic        any_hit, any_free, found;
	logic [2:0]  byte_verdict;

	always_comb begin
		is_send  = 1'b0;
		is_byte  = 1'b0;
		is_clear = 1'b0;
		unique case (req.kind)
			icmp_erm_pkg::KIND_SEND:  is_send  = 1'b1;
			icmp_erm_pkg::KIND_BYTE:  is_byte  = 1'b1;
			icmp_erm_pkg::KIND_CLEAR: is_clear = 1'b1;
			default: ;
		endcase
		sts.has_result = is_send || is_clear || (is_byte && req.last_byte);
	end

	// Per-byte parse; effective values include this byte's updates.
	always_comb begin
		b        = req.data_byte;
		pos_next = (pos_q != icmp_erm_pkg::POS_MAX) ? pos_q + 16'd1 : pos_q;
		ohl_eff  = (!v6_q && pos_q == 16'd0) ? {b[3:0], 2'b00} : ohl_q;
		h        = v6_q ? 6'd0 : ohl_eff;
		ttl_eff  = (!v6_q && pos_q == icmp_erm_pkg::TTL_OFFSET) ? b : ttl_q;
		ib       = {1'b0, h} + 7'd8;
		if (pos_q == {9'd0, ib})
			ihl_eff = v6_q ? icmp_erm_pkg::V6_INNER_HDR_LEN : {b[3:0], 2'b00};
		else
			ihl_eff = ihl_q;
		ibase  = {1'b0, ib} + {2'b00, ihl_eff};
		of_new = icmp_erm_pkg::capture(of_q, pos_q, {2'b00, h}, b);
		if_new = (pos_q >= {9'd0, ib}) ? icmp_erm_pkg::capture(if_q, pos_q, ibase, b) : if_q;
		count  = pos_next;

		outer_ok = (count >= (v6_q ? icmp_erm_pkg::V6_MIN_REPLY_LEN
		                           : icmp_erm_pkg::V4_MIN_REPLY_LEN))
		           && (count >= {9'd0, ib});
		inner_ok = (count >= icmp_erm_pkg::MIN_ERROR_LEN) && (count > {9'd0, ib})
		           && (count >= {8'd0, ibase} + icmp_erm_pkg::ICMP_HDR_LEN);
		if (v6_q) begin
			is_err = (of_new[39:32] == icmp_erm_pkg::V6_TIME_EXCEEDED)
			      || (of_new[39:32] == icmp_erm_pkg::V6_UNREACHABLE);
			is_rep = (of_new[39:32] == icmp_erm_pkg::V6_ECHO_REPLY);
		end else begin
			is_err = (of_new[39:32] == icmp_erm_pkg::V4_TIME_EXCEEDED)
			      || (of_new[39:32] == icmp_erm_pkg::V4_UNREACHABLE);
			is_rep = (of_new[39:32] == icmp_erm_pkg::V4_ECHO_REPLY);
		end
		if (is_err) begin
			try_match = outer_ok && inner_ok && (if_new[31:16] == own_id_q)
			            && (if_new[39:32] == (v6_q ? icmp_erm_pkg::V6_ECHO_REQUEST
			                                       : icmp_erm_pkg::V4_ECHO_REQUEST));
			cand_seq  = if_new[15:0];
		end else begin
			try_match = outer_ok && is_rep && (of_new[31:16] == own_id_q);
			cand_seq  = of_new[15:0];
		end
	end

	// Parallel table search; sequences are unique so at most one hit.
	always_comb begin
		key      = is_send ? req.send_sequence : cand_seq;
		any_hit  = 1'b0;
		found    = 1'b0;
		free_oh  = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			hit[i]  = valid_q[i] && (seq_q[i] == key);
			any_hit = any_hit | hit[i];
			if (!valid_q[i] && !found) begin
				free_oh[i] = 1'b1;
				found      = 1'b1;
			end
		end
		any_free     = found;
		byte_verdict = icmp_erm_pkg::VERDICT_IGNORED;
		if (try_match && any_hit)
			byte_verdict = is_err ? icmp_erm_pkg::VERDICT_ERROR : icmp_erm_pkg::VERDICT_REPLY;
	end

	always_comb begin
		rsp_next = '0;
		if (is_send) begin
			rsp_next.verdict = (any_hit || any_free) ? icmp_erm_pkg::VERDICT_RECORDED
			                                         : icmp_erm_pkg::VERDICT_TABLE_FULL;
			rsp_next.matched_sequence = req.send_sequence;
		end else if (is_clear) begin
			rsp_next.verdict = icmp_erm_pkg::VERDICT_CLEARED;
		end else begin
			rsp_next.verdict        = byte_verdict;
			rsp_next.icmp_kind_seen = of_new[39:32];
			if (byte_verdict != icmp_erm_pkg::VERDICT_IGNORED) begin
				rsp_next.matched_sequence = cand_seq;
				rsp_next.hop_limit        = v6_q ? icmp_erm_pkg::V6_HOP_LIMIT : ttl_eff;
				rsp_next.icmp_length      = (count > {10'd0, h}) ? count - {10'd0, h} : 16'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v6_q     <= 1'b0;
			own_id_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				icmp_erm_pkg::CFG_FAMILY_IPV6:    v6_q     <= cfg_wdata[0];
				icmp_erm_pkg::CFG_OWN_IDENTIFIER: own_id_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			pos_q   <= '0;
			ohl_q   <= '0;
			ihl_q   <= '0;
			ttl_q   <= '0;
			of_q    <= '0;
			if_q    <= '0;
		end else if (cmd.take) begin
			if (is_send) begin
				if (!any_hit) valid_q <= valid_q | free_oh;
			end else if (is_clear) begin
				valid_q <= '0;
			end else if (is_byte) begin
				if (req.last_byte) begin
					if (byte_verdict != icmp_erm_pkg::VERDICT_IGNORED)
						valid_q <= valid_q & ~hit;
					pos_q <= '0;
					ohl_q <= '0;
					ihl_q <= '0;
					ttl_q <= '0;
					of_q  <= '0;
					if_q  <= '0;
				end else begin
					pos_q <= pos_next;
					ohl_q <= ohl_eff;
					ihl_q <= (pos_q >= {9'd0, ib}) ? ihl_eff : ihl_q;
					ttl_q <= ttl_eff;
					of_q  <= of_new;
					if_q  <= if_new;
				end
			end
		end
	end

	// Table contents carry no reset.
	always_ff @(posedge clk) begin
		if (cmd.take && is_send && !any_hit) begin
			for (int i = 0; i < TABLE_DEPTH; i++)
				if (free_oh[i]) seq_q[i] <= req.send_sequence;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) rsp_q <= rsp_next;
	end

	assign rsp = rsp_q;

endmodule

>>> sv/icmp_echo_reply_matcher_top.sv
// Top level: ICMP echo reply matcher, controller plus datapath.
//
//  channel | signals                     | direction | transfer when
//  --------+-----------------------------+-----------+---------------------------
//  req     | req_valid, req_stall, req   | in        | req_valid && !req_stall
//  rsp     | rsp_valid, rsp_stall, rsp   | out       | rsp_valid && !rsp_stall
//  cfg     | cfg_we, cfg_index, cfg_wdata| in        | cfg_we
//
// One item is taken per cycle while req_stall is low; its result (if any)
// shows in the output register on the next cycle. Table lookup is a
// parallel compare over all entries of the table.
// req_stall rises only while a result sits in the output register and the
// sink stalls. Reset empties the table and the packet parser at once; there
// is no clearing pass. Table sequence storage itself is not reset.
module icmp_echo_reply_matcher_top #(
	parameter int TABLE_DEPTH = icmp_erm_pkg::TABLE_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_stall,
	input  icmp_erm_pkg::req_item_t             req,
	output logic                                rsp_valid,
	input  logic                                rsp_stall,
	output icmp_erm_pkg::rsp_item_t             rsp,
	input  logic                                cfg_we,
	input  logic [icmp_erm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [icmp_erm_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	icmp_erm_pkg::ctl_cmd_t cmd;
	icmp_erm_pkg::dp_sts_t  sts;

	// Handshake and output register occupancy.
	icmp_erm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Table, parser, verdict and result register.
	icmp_erm_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.rsp       (rsp),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule
